// ===== rtl/core/fpsd_pkg.sv =====
// Package for the fixed-point shift divider.
// Holds the word width and the structs passed between the cell row and the sequencer.
// No dependencies.
package fpsd_pkg;

  // Width of operands, remainder, divisor and quotient.
  localparam int unsigned DataW = 32;

  typedef logic [DataW-1:0] word_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic load;       // load operand magnitudes and the starting result bit
    logic pre_shift;  // shift divisor and result bit one place up
    logic div_step;   // conditional subtract, then remainder up, result bit down
    logic take;       // the subtraction is accepted in this step
  } cell_ctrl_t;

  // Signals handed from one cell to the next one up.
  typedef struct packed {
    logic rem;        // stored remainder bit
    logic rem_post;   // remainder bit after the conditional subtract
    logic dv;         // stored divisor bit
    logic res;        // stored result-bit marker
    logic diff;       // bit of remainder minus divisor
    logic borrow;     // borrow out of this position
    logic diff_nz;    // some difference bit at or below is set
    logic rem_nz;     // some remainder bit at or below is set
    logic res_nz;     // some result-bit marker at or below is set
  } cell_link_t;

  // Row status seen by the sequencer.
  typedef struct packed {
    logic dv_lt_rem;  // unsigned divisor below remainder
    logic rem_ge_dv;  // signed remainder at or above divisor
    logic rem_nz;     // remainder is nonzero
    logic res_nz;     // result bit is nonzero
  } row_stat_t;

  // Per-item information captured on the input transfer.
  typedef struct packed {
    logic neg;        // result is negated
    logic dbz;        // nonzero value divided by zero
  } item_info_t;

endpackage

// ===== rtl/core/fpsd_cell.sv =====
// One bit slice of the divider row: remainder, divisor, result-bit marker and quotient bit.
// Depends on fpsd_pkg.
module fpsd_cell (
  input  logic               clk_i,
  input  fpsd_pkg::cell_ctrl_t ctrl_i,
  input  logic               load_rem_i,
  input  logic               load_dv_i,
  input  logic               load_res_i,
  input  fpsd_pkg::cell_link_t link_i,   // from the neighbour one place down
  input  logic               res_hi_i,   // result-bit marker of the neighbour one place up
  output fpsd_pkg::cell_link_t link_o,   // to the neighbour one place up
  output logic               q_o
);
  import fpsd_pkg::*;

  logic rem_q, rem_d;
  logic dv_q, dv_d;
  logic res_q, res_d;
  logic q_q, q_d;
  logic diff;
  logic borrow;

  // Ripple subtract slice for remainder minus divisor.
  assign diff   = rem_q ^ dv_q ^ link_i.borrow;
  assign borrow = (~rem_q & dv_q) | (~(rem_q ^ dv_q) & link_i.borrow);

  // Values handed to the next cell up.
  always_comb begin
    link_o.rem      = rem_q;
    link_o.rem_post = ctrl_i.take ? diff : rem_q;
    link_o.dv       = dv_q;
    link_o.res      = res_q;
    link_o.diff     = diff;
    link_o.borrow   = borrow;
    link_o.diff_nz  = link_i.diff_nz | diff;
    link_o.rem_nz   = link_i.rem_nz | rem_q;
    link_o.res_nz   = link_i.res_nz | res_q;
  end

  // Next state of the slice.
  always_comb begin
    rem_d = rem_q;
    dv_d  = dv_q;
    res_d = res_q;
    q_d   = q_q;
    if (ctrl_i.load) begin
      rem_d = load_rem_i;
      dv_d  = load_dv_i;
      res_d = load_res_i;
      q_d   = 1'b0;
    end else if (ctrl_i.pre_shift) begin
      dv_d  = link_i.dv;
      res_d = link_i.res;
    end else if (ctrl_i.div_step) begin
      q_d   = q_q | (ctrl_i.take & res_q);
      rem_d = link_i.rem_post;
      res_d = res_hi_i;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    res_q <= res_d;
    q_q   <= q_d;
  end

  assign q_o = q_q;

endmodule

// ===== rtl/core/fpsd_seq.sv =====
// Sequencer of the divider: pre-shift, quotient steps and the output register.
// Depends on fpsd_pkg.
module fpsd_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  fpsd_pkg::item_info_t info_i,
  input  fpsd_pkg::row_stat_t  stat_i,
  input  fpsd_pkg::word_t      q_i,
  input  logic                 out_ready_i,
  output fpsd_pkg::cell_ctrl_t ctrl_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output fpsd_pkg::word_t      quotient_o,
  output logic                 dbz_o
);
  import fpsd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPre  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_q, state_d;
  logic       first_q, first_d;
  item_info_t info_q, info_d;
  logic       out_valid_q, out_valid_d;
  word_t      quot_q, quot_d;
  logic       dbz_q, dbz_d;
  logic       out_load;

  // Control of the cell row and the state sequence.
  always_comb begin
    state_d          = state_q;
    first_d          = first_q;
    info_d           = info_q;
    out_load         = 1'b0;
    ctrl_o.load      = 1'b0;
    ctrl_o.pre_shift = 1'b0;
    ctrl_o.div_step  = 1'b0;
    ctrl_o.take      = stat_i.rem_ge_dv;
    unique case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          info_d      = info_i;
          first_d     = 1'b1;
          state_d     = info_i.dbz ? StDone : StPre;
        end
      end
      StPre: begin
        if (stat_i.dv_lt_rem) begin
          ctrl_o.pre_shift = 1'b1;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        // The first step always runs; later ones while both values are nonzero.
        if (first_q || (stat_i.rem_nz && stat_i.res_nz)) begin
          ctrl_o.div_step = 1'b1;
          first_d         = 1'b0;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register: sign correction and the divide-by-zero case.
  always_comb begin
    out_valid_d = out_valid_q;
    quot_d      = quot_q;
    dbz_d       = dbz_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      dbz_d       = info_q.dbz;
      if (info_q.dbz) begin
        quot_d = '0;
      end else if (info_q.neg) begin
        quot_d = (~q_i) + word_t'(1);
      end else begin
        quot_d = q_i;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    info_q  <= info_d;
    quot_q  <= quot_d;
    dbz_q   <= dbz_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign quotient_o  = quot_q;
  assign dbz_o       = dbz_q;

endmodule

// ===== rtl/core/fixed_point_shift_divider_core.sv =====
// Signed 16.16 shift-subtract divider built as a row of 32 bit-slice cells.
// After the input transfer the row is loaded and runs K pre-shift steps (K 0 to 31), then N
// quotient steps (N 1 to 32), before the result goes to the output register; a nonzero value
// divided by zero goes straight to the output register. One step per cycle, set by the borrow
// chain of the row. A new transfer is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the output.
module fixed_point_shift_divider_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] numerator, [63:32] denominator
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] quotient
  output logic        m_axis_tuser    // [0] divide_by_zero
);
  import fpsd_pkg::*;

  word_t      numerator;
  word_t      denominator;
  word_t      num_mag;
  word_t      den_mag;
  word_t      q_row;
  item_info_t info;
  row_stat_t  stat;
  cell_ctrl_t ctrl;
  cell_link_t link [DataW+1];
  cell_link_t top;
  logic       in_fire;
  logic       ovf;

  assign numerator   = s_axis_tdata[DataW-1:0];
  assign denominator = s_axis_tdata[2*DataW-1:DataW];
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  // Operand magnitudes, wrapping for the most negative value.
  assign num_mag = numerator[DataW-1] ? ((~numerator) + word_t'(1)) : numerator;
  assign den_mag = denominator[DataW-1] ? ((~denominator) + word_t'(1)) : denominator;

  assign info.neg = numerator[DataW-1] ^ denominator[DataW-1];
  assign info.dbz = (denominator == '0) && (numerator != '0);

  // Bottom of the chain: no borrow, nothing below.
  assign link[0] = '0;

  // Row of bit-slice cells, least significant at index 0.
  for (genvar i = 0; i < DataW; i++) begin : g_cell
    logic res_hi;
    if (i == DataW - 1) begin : g_top
      assign res_hi = 1'b0;
    end else begin : g_mid
      assign res_hi = link[i+2].res;
    end
    fpsd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_rem_i (num_mag[i]),
      .load_dv_i  (den_mag[i]),
      .load_res_i (logic'(i == FRAC_BITS)),
      .link_i     (link[i]),
      .res_hi_i   (res_hi),
      .link_o     (link[i+1]),
      .q_o        (q_row[i])
    );
  end

  // Compares taken from the top of the chain.
  assign top            = link[DataW];
  assign ovf            = (top.rem ^ top.dv) & (top.diff ^ top.rem);
  assign stat.dv_lt_rem = !top.borrow && top.diff_nz;
  assign stat.rem_ge_dv = !(top.diff ^ ovf);
  assign stat.rem_nz    = top.rem_nz;
  assign stat.res_nz    = top.res_nz;

  fpsd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .info_i      (info),
    .stat_i      (stat),
    .q_i         (q_row),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .quotient_o  (m_axis_tdata),
    .dbz_o       (m_axis_tuser)
  );

endmodule

// ===== rtl/core/fpsd_checker.sv =====
// Port-level checks for the fixed-point shift divider, bound to the top level.
// No package dependencies.
module fpsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Only one item is in flight: no transfer is taken in the cycle after one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // A result cannot appear in the cycle after its input transfer.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // A divide-by-zero result carries a zero quotient.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("divide-by-zero result with nonzero quotient");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind fixed_point_shift_divider_core fpsd_checker u_fpsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_fixed_point_shift_divider_core.sv =====
// Self-checking testbench for the signed 16.16 shift-subtract divider core.
// A directed table is followed by random operands; each result is checked against the value typed
// in its table row or an in-bench model. Depends on fpsd_pkg and fixed_point_shift_divider_core.
module tb_fixed_point_shift_divider_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsd_pkg::word_t;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned LongHold    = 150;   // cycles the result side holds off once
  localparam int unsigned HoldAt      = 60;    // result count at which that hold starts
  localparam int unsigned IdleLimit   = 2000;  // cycles without any transfer before giving up
  localparam int unsigned DrainCycles = 80;    // longest division plus margin
  localparam int unsigned MaxReports  = 10;
  localparam word_t       One         = 32'h0001_0000;

  // Quotient and flag as the block returns them.
  typedef struct packed {
    word_t quot;
    logic  dbz;
  } quot_t;

  // One row of the directed table.
  typedef struct packed {
    word_t num;
    word_t den;
    logic  known;  // the expected result is typed in below
    quot_t res;
  } div_case_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] numerator, [63:32] denominator
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] quotient
  logic        m_axis_tuser;   // [0] divide_by_zero

  quot_t       pending_quotients[$];
  div_case_t   div_cases[22];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned idle_cycles;

  fixed_point_shift_divider_core #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sign-and-magnitude restoring division, as the block is meant to compute it.
  function automatic quot_t divide_fixed(word_t num, word_t den);
    quot_t r;
    logic  neg;
    word_t rem;
    word_t dv;
    word_t res_bit;
    word_t q;
    neg     = num[31] ^ den[31];
    rem     = num[31] ? (32'd0 - num) : num;
    dv      = den[31] ? (32'd0 - den) : den;
    res_bit = word_t'(1) << FracBits;
    q       = '0;
    r.dbz   = 1'b0;
    if (dv == '0 && rem != '0) begin
      r.quot = '0;
      r.dbz  = 1'b1;
      return r;
    end
    // Line the divisor up with the dividend; the result bit may wrap to zero.
    while (dv < rem) begin
      dv      = dv << 1;
      res_bit = res_bit << 1;
    end
    // Decide quotient bits from the top using a signed compare.
    do begin
      if ($signed(rem) >= $signed(dv)) begin
        rem = rem - dv;
        q   = q | res_bit;
      end
      rem     = rem << 1;
      res_bit = res_bit >> 1;
    end while (res_bit != '0 && rem != '0);
    r.quot = neg ? (32'd0 - q) : q;
    return r;
  endfunction

  // Random operand: wide values, with small, power-of-two, extreme, integral and zero ones mixed in.
  function automatic word_t pick_operand();
    word_t w;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    w    = $urandom;
    case (kind)
      4, 5: begin
        w = $urandom & 32'h001F_FFFF;
        if ($urandom_range(0, 1) == 1) w = 32'd0 - w;
      end
      6: begin
        w = word_t'(1) << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) w = 32'd0 - w;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7FFF_FFFF;
          2:       w = 32'hFFFF_FFFF;
          3:       w = 32'h0000_0001;
          default: w = One;
        endcase
      end
      8: begin
        w = word_t'($urandom_range(1, 200)) << FracBits;
        if ($urandom_range(0, 1) == 1) w = 32'd0 - w;
      end
      9:       w = '0;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Offer one division and record the expected result once the transfer happens.
  task automatic offer_division(word_t num, word_t den, logic known, quot_t typed);
    int unsigned gap;
    gap = (((items_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {den, num};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_quotients.push_back(known ? typed : divide_fixed(num, den));
    items_sent++;
  endtask

  task automatic report_mismatch(string what, quot_t exp_r, quot_t got_r);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch (%s): expected quotient %h dbz %b, got quotient %h dbz %b",
               what, exp_r.quot, exp_r.dbz, got_r.quot, got_r.dbz);
  endtask

  // Directed table: extremes, division by zero, wrapping magnitudes and result-bit overflow.
  initial begin
    div_cases[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1, '{One, 1'b0}};
    div_cases[1]  = '{One,           32'h0000_0000, 1'b1, '{32'h0, 1'b1}};
    div_cases[2]  = '{32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1}};
    div_cases[3]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b1}};
    div_cases[4]  = '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b1}};
    div_cases[5]  = '{One,           One,           1'b1, '{One, 1'b0}};
    div_cases[6]  = '{32'hFFFF_0000, One,           1'b1, '{32'hFFFF_0000, 1'b0}};
    div_cases[7]  = '{32'hFFFF_0000, 32'hFFFF_0000, 1'b1, '{One, 1'b0}};
    div_cases[8]  = '{32'h0000_0000, One,           1'b1, '{32'h0, 1'b0}};
    div_cases[9]  = '{32'h0003_0000, 32'h0002_0000, 1'b1, '{32'h0001_8000, 1'b0}};
    div_cases[10] = '{32'h0000_0000, 32'h8000_0000, 1'b0, '{32'h0, 1'b0}};
    div_cases[11] = '{32'h8000_0000, 32'h0000_0001, 1'b0, '{32'h0, 1'b0}};
    div_cases[12] = '{32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, 1'b0}};
    div_cases[13] = '{32'h0000_0001, 32'h8000_0000, 1'b0, '{32'h0, 1'b0}};
    div_cases[14] = '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '{32'h0, 1'b0}};
    div_cases[15] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, 1'b0}};
    div_cases[16] = '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0, '{32'h0, 1'b0}};
    div_cases[17] = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '{32'h0, 1'b0}};
    div_cases[18] = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{32'h0, 1'b0}};
    div_cases[19] = '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}};
    div_cases[20] = '{One,           32'h0003_0000, 1'b0, '{32'h0, 1'b0}};
    div_cases[21] = '{32'h4000_0000, 32'h0000_8000, 1'b0, '{32'h0, 1'b0}};
  end

  // Reset, stimulus and end of run.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    mismatches    = 0;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (div_cases[i])
      offer_division(div_cases[i].num, div_cases[i].den, div_cases[i].known, div_cases[i].res);
    for (int unsigned i = 0; i < RandomItems; i++)
      offer_division(pick_operand(), pick_operand(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    // Let every outstanding division come back, then watch for stray results.
    while (pending_quotients.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_quotients.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random hold-offs, one long hold to back the block up, and checking.
  initial begin
    int unsigned stall;
    quot_t       got_r;
    quot_t       exp_r;
    m_axis_tready <= 1'b0;
    results_seen  = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (results_seen == HoldAt)
        stall = LongHold;
      else
        stall = (((results_seen / 50) % 3) == 1) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got_r.quot = m_axis_tdata;
      got_r.dbz  = m_axis_tuser;
      results_seen++;
      if (pending_quotients.size() == 0) begin
        report_mismatch("no result expected", '0, got_r);
      end else begin
        exp_r = pending_quotients.pop_front();
        if (got_r.quot !== exp_r.quot || got_r.dbz !== exp_r.dbz)
          report_mismatch("wrong result", exp_r, got_r);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/core/fpsd_pkg.sv
rtl/core/fpsd_cell.sv
rtl/core/fpsd_seq.sv
rtl/core/fixed_point_shift_divider_core.sv
rtl/core/fpsd_checker.sv
sim/tb_fixed_point_shift_divider_core.sv
